[rtl/hba_pkg.sv]
package hba_pkg;

    localparam int INDEX_W       = 12;
    localparam int CFG_W         = 7;
    localparam int CFG_RESET     = 64;
    localparam int NUM_WORDS_DEF = 64;
    localparam int WORD_BITS_DEF = 64;
    localparam int DIV_SHIFT     = 24;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic rel_div;
        logic rel_fix;
        logic rel_chk;
        logic rel_write;
        logic out_load;
    } hba_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_release;
        logic scan_found;
        logic scan_fail;
        logic rel_outside;
    } hba_sts_t;

endpackage

[rtl/hba_ctrl.sv]
module hba_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  hba_pkg::hba_sts_t sts,
    output hba_pkg::hba_cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_REL_DIV = 3'd3;
    localparam logic [2:0] ST_REL_FIX = 3'd4;
    localparam logic [2:0] ST_REL_CHK = 3'd5;
    localparam logic [2:0] ST_REL_WR  = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.is_release ? ST_REL_DIV : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_found || sts.scan_fail)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_REL_DIV:
            begin
                cmd.rel_div = 1'b1;
                state_next  = ST_REL_FIX;
            end
            ST_REL_FIX:
            begin
                cmd.rel_fix = 1'b1;
                state_next  = ST_REL_CHK;
            end
            ST_REL_CHK:
            begin
                cmd.rel_chk = 1'b1;
                state_next  = sts.rel_outside ? ST_FINISH : ST_REL_WR;
            end
            ST_REL_WR:
            begin
                cmd.rel_write = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/hba_dp.sv]
module hba_dp
#(
    parameter int NUM_WORDS = hba_pkg::NUM_WORDS_DEF,
    parameter int WORD_BITS = hba_pkg::WORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hba_pkg::hba_cmd_t             cmd,
    output hba_pkg::hba_sts_t             sts,
    input  logic                          opcode,
    input  logic [hba_pkg::INDEX_W-1:0]   release_index,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [hba_pkg::CFG_W-1:0]     words_in_use,
    output logic [hba_pkg::INDEX_W-1:0]   granted_index,
    output logic                          no_free,
    output logic                          release_fault,
    output logic [hba_pkg::INDEX_W-1:0]   highest_granted
);

    localparam int INDEX_W = hba_pkg::INDEX_W;
    localparam int WADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_RAW = $clog2(NUM_WORDS + 1);
    localparam int CNT_W   = (CNT_RAW > hba_pkg::CFG_W) ? CNT_RAW : hba_pkg::CFG_W;
    localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int IDX_W   = WADDR_W + BIT_W;
    localparam int PROD_W  = INDEX_W + hba_pkg::DIV_SHIFT;
    localparam int RECIP   = (1 << hba_pkg::DIV_SHIFT) / WORD_BITS;

    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic                  wr_en;
    logic [WADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic                  rd_en;
    logic [WADDR_W-1:0]    rd_addr;

    logic [hba_pkg::CFG_W-1:0] wiu_reg, wiu_next;
    logic [WADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [WADDR_W-1:0]    hint_reg, hint_next;
    logic [IDX_W-1:0]      highest_reg, highest_next;
    logic [CNT_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                  pend_reg, pend_next;
    logic [WADDR_W-1:0]    pend_addr_reg, pend_addr_next;

    logic [INDEX_W-1:0]    idx_reg, idx_next;
    logic [INDEX_W-1:0]    q_reg, q_next;
    logic [INDEX_W-1:0]    relw_reg, relw_next;
    logic [BIT_W-1:0]      relb_reg, relb_next;
    logic [INDEX_W-1:0]    res_granted_reg, res_granted_next;
    logic                  res_nofree_reg, res_nofree_next;
    logic                  res_fault_reg, res_fault_next;
    logic [INDEX_W-1:0]    out_granted_reg, out_granted_next;
    logic                  out_nofree_reg, out_nofree_next;
    logic                  out_fault_reg, out_fault_next;
    logic [INDEX_W-1:0]    out_highest_reg, out_highest_next;

    logic [CNT_W-1:0]      cfg_ext;
    logic [CNT_W-1:0]      active_n;
    logic [BIT_W-1:0]      fz;
    logic                  found;
    logic                  exhausted;
    logic [IDX_W-1:0]      grant_idx;
    logic [PROD_W-1:0]     prod;
    logic [INDEX_W-1:0]    rem;
    logic                  outside;
    logic [WORD_BITS-1:0]  rel_mask;

    always_comb
    begin
        cfg_ext = CNT_W'(wiu_reg);
        if (wiu_reg == '0)
        begin
            active_n = CNT_W'(1);
        end
        else if (cfg_ext > CNT_W'(NUM_WORDS))
        begin
            active_n = CNT_W'(NUM_WORDS);
        end
        else
        begin
            active_n = cfg_ext;
        end
    end

    assign fz        = first_zero(rd_data_reg);
    assign found     = pend_reg && (|(~rd_data_reg));
    assign exhausted = !found && (scan_addr_reg >= active_n);
    assign grant_idx = IDX_W'(pend_addr_reg) * IDX_W'(WORD_BITS) + IDX_W'(fz);
    assign prod      = PROD_W'(idx_reg) * PROD_W'(RECIP);
    assign rem       = idx_reg - INDEX_W'(q_reg * WORD_BITS);
    assign outside   = CMP_W'(relw_reg) >= CMP_W'(active_n);
    assign rel_mask  = WORD_BITS'(1) << relb_reg;

    always_comb
    begin
        sts.clear_last  = (clr_addr_reg == WADDR_W'(NUM_WORDS - 1));
        sts.is_release  = (opcode == hba_pkg::OP_RELEASE);
        sts.scan_found  = found;
        sts.scan_fail   = exhausted && (hint_reg == '0);
        sts.rel_outside = outside;
    end

    always_comb
    begin
        wiu_next         = wiu_reg;
        clr_addr_next    = clr_addr_reg;
        hint_next        = hint_reg;
        highest_next     = highest_reg;
        scan_addr_next   = scan_addr_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        idx_next         = idx_reg;
        q_next           = q_reg;
        relw_next        = relw_reg;
        relb_next        = relb_reg;
        res_granted_next = res_granted_reg;
        res_nofree_next  = res_nofree_reg;
        res_fault_next   = res_fault_reg;
        out_granted_next = out_granted_reg;
        out_nofree_next  = out_nofree_reg;
        out_fault_next   = out_fault_reg;
        out_highest_next = out_highest_reg;
        wr_en            = 1'b0;
        wr_addr          = pend_addr_reg;
        wr_data          = rd_data_reg;
        rd_en            = 1'b0;
        rd_addr          = WADDR_W'(scan_addr_reg);

        if (cfg_valid && cfg_ready)
        begin
            wiu_next = words_in_use;
        end

        if (cmd.clear)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
            if (!sts.clear_last)
            begin
                clr_addr_next = clr_addr_reg + WADDR_W'(1);
            end
        end

        if (cmd.load)
        begin
            idx_next       = release_index;
            scan_addr_next = CNT_W'(hint_reg);
            pend_next      = 1'b0;
        end

        if (cmd.scan)
        begin
            if (found)
            begin
                wr_en            = 1'b1;
                wr_addr          = pend_addr_reg;
                wr_data          = rd_data_reg | (WORD_BITS'(1) << fz);
                pend_next        = 1'b0;
                res_granted_next = INDEX_W'(grant_idx);
                res_nofree_next  = 1'b0;
                res_fault_next   = 1'b0;
                if (pend_addr_reg > hint_reg)
                begin
                    hint_next = pend_addr_reg;
                end
                if (grant_idx > highest_reg)
                begin
                    highest_next = grant_idx;
                end
            end
            else if (exhausted)
            begin
                pend_next = 1'b0;
                if (hint_reg != '0)
                begin
                    // wrap around and rescan from word zero
                    hint_next      = '0;
                    scan_addr_next = '0;
                end
                else
                begin
                    res_granted_next = '0;
                    res_nofree_next  = 1'b1;
                    res_fault_next   = 1'b0;
                end
            end
            else
            begin
                rd_en          = 1'b1;
                rd_addr        = WADDR_W'(scan_addr_reg);
                pend_next      = 1'b1;
                pend_addr_next = WADDR_W'(scan_addr_reg);
                scan_addr_next = scan_addr_reg + CNT_W'(1);
            end
        end

        if (cmd.rel_div)
        begin
            // quotient estimate, low by at most one
            q_next = INDEX_W'(prod >> hba_pkg::DIV_SHIFT);
        end

        if (cmd.rel_fix)
        begin
            if (rem >= INDEX_W'(WORD_BITS))
            begin
                relw_next = q_reg + INDEX_W'(1);
                relb_next = BIT_W'(rem - INDEX_W'(WORD_BITS));
            end
            else
            begin
                relw_next = q_reg;
                relb_next = BIT_W'(rem);
            end
        end

        if (cmd.rel_chk)
        begin
            res_granted_next = '0;
            res_nofree_next  = 1'b0;
            res_fault_next   = outside;
            if (!outside)
            begin
                rd_en   = 1'b1;
                rd_addr = WADDR_W'(relw_reg);
            end
        end

        if (cmd.rel_write)
        begin
            wr_en          = 1'b1;
            wr_addr        = WADDR_W'(relw_reg);
            wr_data        = rd_data_reg & ~rel_mask;
            res_fault_next = ((rd_data_reg & rel_mask) == '0);
            if (WADDR_W'(relw_reg) < hint_reg)
            begin
                hint_next = WADDR_W'(relw_reg);
            end
        end

        if (cmd.out_load)
        begin
            out_granted_next = res_granted_reg;
            out_nofree_next  = res_nofree_reg;
            out_fault_next   = res_fault_reg;
            out_highest_next = INDEX_W'(highest_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wiu_reg       <= hba_pkg::CFG_W'(hba_pkg::CFG_RESET);
            clr_addr_reg  <= '0;
            hint_reg      <= '0;
            highest_reg   <= '0;
            scan_addr_reg <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            wiu_reg       <= wiu_next;
            clr_addr_reg  <= clr_addr_next;
            hint_reg      <= hint_next;
            highest_reg   <= highest_next;
            scan_addr_reg <= scan_addr_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg   <= pend_addr_next;
        idx_reg         <= idx_next;
        q_reg           <= q_next;
        relw_reg        <= relw_next;
        relb_reg        <= relb_next;
        res_granted_reg <= res_granted_next;
        res_nofree_reg  <= res_nofree_next;
        res_fault_reg   <= res_fault_next;
        out_granted_reg <= out_granted_next;
        out_nofree_reg  <= out_nofree_next;
        out_fault_reg   <= out_fault_next;
        out_highest_reg <= out_highest_next;
    end

    assign granted_index   = out_granted_reg;
    assign no_free         = out_nofree_reg;
    assign release_fault   = out_fault_reg;
    assign highest_granted = out_highest_reg;

endmodule

[rtl/hinted_bitmap_allocator.sv]
// acquire: reads words from the hint word on (one read per cycle) and sets the first free bit it finds;
//   when the first pass runs out it wraps and makes a second pass from word 0
// release: divide, correct, read, write back; the read and write back are skipped when out of range
// throughput: one transaction at a time; next input taken on the cycle after the result is staged
// reset: asynchronous; then a clearing pass zeroes the bitmap memory
//   while no input transaction is accepted (configuration writes are taken throughout)
module hinted_bitmap_allocator
#(
    parameter int NUM_WORDS = hba_pkg::NUM_WORDS_DEF,
    parameter int WORD_BITS = hba_pkg::WORD_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [hba_pkg::INDEX_W-1:0] release_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [hba_pkg::INDEX_W-1:0] granted_index,
    output logic                        no_free,
    output logic                        release_fault,
    output logic [hba_pkg::INDEX_W-1:0] highest_granted,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [hba_pkg::CFG_W-1:0]   words_in_use
);

    hba_pkg::hba_cmd_t cmd;
    hba_pkg::hba_sts_t sts;

    assign cfg_ready = 1'b1;

    hba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    hba_dp
    #(
        .NUM_WORDS (NUM_WORDS),
        .WORD_BITS (WORD_BITS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .opcode          (opcode),
        .release_index   (release_index),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .words_in_use    (words_in_use),
        .granted_index   (granted_index),
        .no_free         (no_free),
        .release_fault   (release_fault),
        .highest_granted (highest_granted)
    );

endmodule
